FILE: hdl/cdq_pkg.sv
// Shared types and constants for the circular deque core.
// No dependencies; imported by cdq_ring and circular_deque_core.
package cdq_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = 3;
  localparam int VALUE_W = 32;
  localparam int FUNC_W  = 3;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_REAR  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [PTR_W-1:0]   addr;
    status_t            status;
    logic               empty;
    logic               full;
    logic [COUNT_W-1:0] count;
  } cdq_op_t;

endpackage

FILE: hdl/circular_deque_core.sv
// Circular deque core: slot memory, request sequencing and result register.
// Depends on cdq_pkg and cdq_ring.
//
// A double-ended queue of DEPTH-1 entries in a ring of DEPTH slots held in a
// synchronous memory. Each request item gives exactly one result item. Pushes,
// refused requests and unused function codes register their result directly
// on acceptance; accepted pops and peeks first pass through the registered read
// data of the slot memory and the S_READ state. One request is in flight at a
// time, so a new item is taken only once the last result has left or is being
// taken. A refused request (push when full, pop or peek when empty) returns an
// error status with a zero value and leaves the deque unchanged. DEPTH must be
// a power of two. The slot memory is not cleared at reset.
module circular_deque_core import cdq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // func[2:0], push_value[34:3], zero fill
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // read_value[31:0], status[33:32],
                                        // is_empty_flag[34], is_full_flag[35],
                                        // entry_count[38:36], zero fill
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t             state;
  cdq_op_t            op;
  logic               take;
  func_t              func;
  logic [DATA_W-1:0]  push_value;
  logic [DATA_W-1:0]  slots [DEPTH];
  logic [DATA_W-1:0]  rdata;
  logic [DATA_W-1:0]  out_value;
  status_t            out_status;
  logic               out_empty;
  logic               out_full;
  logic [COUNT_W-1:0] out_count;

  assign func       = func_t'(s_tdata[FUNC_W-1:0]);
  assign push_value = s_tdata[FUNC_W +: DATA_W];
  assign s_tready   = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign take       = s_tvalid && s_tready;

  cdq_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .func (func),
    .op   (op)
  );

  always_ff @(posedge clk) begin
    if (take && op.wr) begin
      slots[op.addr] <= push_value;
    end
    rdata <= slots[op.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && op.rd) begin
            state <= S_READ;
          end
          if (take && !op.rd) begin
            m_tvalid <= 1'b1;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        S_READ: begin
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_value  <= '0;
      out_status <= op.status;
      out_empty  <= op.empty;
      out_full   <= op.full;
      out_count  <= op.count;
    end else if (state == S_READ) begin
      out_value <= rdata;
    end
  end

  assign m_tdata = {1'b0, out_count, out_full, out_empty, out_status,
                    VALUE_W'(signed'(out_value))};

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    take && op.rd |-> ##2 m_tvalid)
    else $error("pop or peek result not presented two cycles after acceptance");

  a_push_not_empty: assert property (@(posedge clk) disable iff (rst)
    take && op.wr |=> m_tvalid && !out_empty && (out_status == ST_OK))
    else $error("accepted push did not leave the deque non-empty");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    take && (op.status == ST_FULL) |=> out_full && (out_count == COUNT_W'(DEPTH - 1)))
    else $error("refused push reported a count other than a full ring");

endmodule

FILE: hdl/cdq_ring.sv
// Front and rear pointers of the deque ring; decodes each request into a
// slot access, a status and the flags after the step. Depends on cdq_pkg.
module cdq_ring import cdq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  func_t       func,
  output cdq_op_t     op
);

  logic [PTR_W-1:0] front;
  logic [PTR_W-1:0] rear;
  logic [PTR_W-1:0] front_next;
  logic [PTR_W-1:0] rear_next;
  logic [PTR_W-1:0] front_inc;
  logic [PTR_W-1:0] front_dec;
  logic [PTR_W-1:0] rear_inc;
  logic [PTR_W-1:0] rear_dec;
  logic [PTR_W-1:0] fill;
  logic             empty_now;
  logic             full_now;

  assign front_inc = front + PTR_W'(1);
  assign front_dec = front - PTR_W'(1);
  assign rear_inc  = rear + PTR_W'(1);
  assign rear_dec  = rear - PTR_W'(1);
  assign empty_now = (front == rear);
  assign full_now  = (rear_inc == front);

  always_comb begin
    front_next = front;
    rear_next  = rear;
    op.wr      = 1'b0;
    op.rd      = 1'b0;
    op.addr    = rear;
    op.status  = ST_OK;
    case (func)
      FN_PUSH_FRONT: begin
        if (full_now) begin
          op.status = ST_FULL;
        end else begin
          op.wr      = 1'b1;
          op.addr    = front;
          front_next = front_dec;
        end
      end
      FN_PUSH_REAR: begin
        if (full_now) begin
          op.status = ST_FULL;
        end else begin
          op.wr     = 1'b1;
          op.addr   = rear_inc;
          rear_next = rear_inc;
        end
      end
      FN_POP_FRONT: begin
        if (empty_now) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd      = 1'b1;
          op.addr    = front_inc;
          front_next = front_inc;
        end
      end
      FN_POP_REAR: begin
        if (empty_now) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd     = 1'b1;
          op.addr   = rear;
          rear_next = rear_dec;
        end
      end
      FN_PEEK_FRONT: begin
        if (empty_now) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd   = 1'b1;
          op.addr = front_inc;
        end
      end
      FN_PEEK_REAR: begin
        if (empty_now) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd   = 1'b1;
          op.addr = rear;
        end
      end
      default: begin
      end
    endcase
    fill     = rear_next - front_next;
    op.empty = (front_next == rear_next);
    op.full  = ((rear_next + PTR_W'(1)) == front_next);
    op.count = COUNT_W'(fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
    end else if (take) begin
      front <= front_next;
      rear  <= rear_next;
    end
  end

endmodule
